@@ rtl/owbm_pkg.sv @@
package owbm_pkg;

  // Configuration register file shape
  localparam int NUM_REGS = 8;
  localparam int REG_W    = 10;
  localparam int IDX_W    = 3;

  // Default timer width in bits
  localparam int DEF_TIMER_BITS = 10;

  // Bits moved by a byte command
  localparam int BYTE_BITS = 8;

  // Fixed slot pieces
  localparam int GAP_TICKS      = 2;
  localparam int READ_LOW_TICKS = 2;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [IDX_W-1:0] REG_ZERO_LOW      = 3'd3;
  localparam logic [IDX_W-1:0] REG_ONE_LOW       = 3'd4;
  localparam logic [IDX_W-1:0] REG_ONE_TAIL      = 3'd5;
  localparam logic [IDX_W-1:0] REG_READ_SAMPLE   = 3'd6;
  localparam logic [IDX_W-1:0] REG_READ_TAIL     = 3'd7;

  // Reset values, register 0 in the lowest slice
  localparam logic [NUM_REGS-1:0][REG_W-1:0] CFG_RESET = {
    10'd53, 10'd7, 10'd65, 10'd3, 10'd65, 10'd425, 10'd80, 10'd490
  };

  // Registers whose value range starts at one (zero reads as one)
  localparam logic [NUM_REGS-1:0] CFG_MIN_ONE = 8'b0001_1011;

  // Bus commands
  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_RESET = 3'd1,
    ACT_WBYTE = 3'd2,
    ACT_RBYTE = 3'd3,
    ACT_WBIT  = 3'd4,
    ACT_RBIT  = 3'd5
  } action_t;

  // Slot sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_WAIT  = 4'd2,
    PH_RST_TAIL  = 4'd3,
    PH_RECOVER   = 4'd4,
    PH_WLOW      = 4'd5,
    PH_WTAIL     = 4'd6,
    PH_RLOW      = 4'd7,
    PH_RWAIT     = 4'd8,
    PH_RTAIL     = 4'd9
  } phase_t;

endpackage

@@ rtl/onewire_bus_master_unit.sv @@
// Channel  | Dir | Fields (low bit up)                                  | Handshake
// in_      | in  | tuser: action[2:0]; tdata: data_byte[7:0], line_in[8] | tvalid/tready
// out_     | out | tdata: drive_low, busy_res, done_res, presence,       | tvalid/tready
//          |     |        read_data[11:4]                               |
// cfg_     | in  | cfg_index, cfg_wdata                                 | cfg_we
//
// One tick transaction in, one result transaction out; a new tick
// is taken every cycle while the result register is empty or being drained.
// The slot sequencer, its timer and the result register sit in one stage.
// Synchronous active-low reset clears the sequencer, results and the timing
// registers to their defaults. A stall on out_tready holds in_tready low.
module onewire_bus_master_unit #(
  parameter int TIMER_BITS = owbm_pkg::DEF_TIMER_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // action[2:0]
  input  logic [2:0]                 in_tuser,
  // data_byte[7:0], line_in[8], zero fill above
  input  logic [15:0]                in_tdata,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // drive_low[0], busy_res[1], done_res[2], presence[3], read_data[11:4], zero fill
  output logic [15:0]                out_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  input  logic                       cfg_we,
  input  logic [owbm_pkg::IDX_W-1:0] cfg_index,
  input  logic [owbm_pkg::REG_W-1:0] cfg_wdata
);

  localparam int CW = (TIMER_BITS > owbm_pkg::REG_W) ? TIMER_BITS : owbm_pkg::REG_W;
  localparam logic [CW-1:0] TOP = CW'((1 << TIMER_BITS) - 1);
  localparam int ADV_STEPS = 4;

  typedef logic [owbm_pkg::NUM_REGS-1:0][TIMER_BITS-1:0] dur_set_t;

  // Clamp a register value into the timer range
  function automatic logic [TIMER_BITS-1:0] fit(logic [owbm_pkg::REG_W-1:0] v, logic min_one);
    logic [CW-1:0] x;
    x = CW'(v);
    if (min_one && x == '0) x = CW'(1);
    if (x > TOP) x = TOP;
    return x[TIMER_BITS-1:0];
  endfunction

  // Ticks to spend in a phase
  function automatic logic [TIMER_BITS-1:0] dur_of(owbm_pkg::phase_t p, logic b0, dur_set_t fd);
    logic [TIMER_BITS-1:0] d;
    case (p)
      owbm_pkg::PH_RST_LOW:  d = fd[owbm_pkg::REG_RESET_LOW];
      owbm_pkg::PH_RST_WAIT: d = fd[owbm_pkg::REG_PRESENCE_WAIT];
      owbm_pkg::PH_RST_TAIL: d = fd[owbm_pkg::REG_RESET_TAIL];
      owbm_pkg::PH_RECOVER:  d = TIMER_BITS'(owbm_pkg::GAP_TICKS);
      owbm_pkg::PH_WLOW:     d = b0 ? fd[owbm_pkg::REG_ONE_LOW] : fd[owbm_pkg::REG_ZERO_LOW];
      owbm_pkg::PH_WTAIL:    d = fd[owbm_pkg::REG_ONE_TAIL];
      owbm_pkg::PH_RLOW:     d = TIMER_BITS'(owbm_pkg::READ_LOW_TICKS);
      owbm_pkg::PH_RWAIT:    d = fd[owbm_pkg::REG_READ_SAMPLE];
      owbm_pkg::PH_RTAIL:    d = fd[owbm_pkg::REG_READ_TAIL];
      default:               d = '0;
    endcase
    return d;
  endfunction

  logic [owbm_pkg::NUM_REGS-1:0][owbm_pkg::REG_W-1:0] cfg_r;
  dur_set_t fdur;

  owbm_pkg::phase_t      phase_r, phase_nxt;
  logic [TIMER_BITS-1:0] timer_r, timer_nxt;
  logic [3:0]            bitcnt_r, bitcnt_nxt;
  logic [7:0]            shift_r, shift_nxt;
  owbm_pkg::action_t     op_r, op_nxt;
  logic                  pres_r, pres_nxt;
  logic [7:0]            rdata_r, rdata_nxt;
  logic                  drive, done;

  logic                  out_tvalid_r;
  logic [15:0]           out_tdata_r;

  logic                  accept;
  owbm_pkg::action_t     act;
  logic                  line;

  assign act       = owbm_pkg::action_t'(in_tuser);
  assign line      = in_tdata[8];
  assign in_tready = !out_tvalid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Timing registers, written at any time the enable is high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= owbm_pkg::CFG_RESET;
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  // Clamp every register into the timer range
  always_comb begin
    for (int i = 0; i < owbm_pkg::NUM_REGS; i++) begin
      fdur[i] = fit(cfg_r[i], owbm_pkg::CFG_MIN_ONE[i]);
    end
  end

  // One tick of the slot sequencer
  always_comb begin
    logic                  go;
    logic                  fin;
    logic                  is_wr;
    logic [3:0]            total;
    logic [2:0]            idx;
    logic [TIMER_BITS-1:0] d;

    phase_nxt  = phase_r;
    timer_nxt  = timer_r;
    bitcnt_nxt = bitcnt_r;
    shift_nxt  = shift_r;
    op_nxt     = op_r;
    pres_nxt   = pres_r;
    rdata_nxt  = rdata_r;
    drive      = 1'b0;
    done       = 1'b0;
    go         = 1'b0;
    fin        = 1'b0;
    idx        = '0;
    d          = '0;

    // start a command on an idle bus; anything else while busy is dropped
    if (accept && phase_r == owbm_pkg::PH_IDLE &&
        act inside {[owbm_pkg::ACT_RESET:owbm_pkg::ACT_RBIT]}) begin
      op_nxt = act;
      if (act == owbm_pkg::ACT_RESET) begin
        phase_nxt = owbm_pkg::PH_RST_LOW;
      end else begin
        bitcnt_nxt = (act == owbm_pkg::ACT_WBYTE || act == owbm_pkg::ACT_RBYTE) ?
                     4'(owbm_pkg::BYTE_BITS) : 4'd1;
        case (act)
          owbm_pkg::ACT_WBYTE: shift_nxt = in_tdata[7:0];
          owbm_pkg::ACT_WBIT:  shift_nxt = {7'd0, in_tdata[0]};
          default:             shift_nxt = '0;
        endcase
        phase_nxt = owbm_pkg::PH_RECOVER;
      end
      timer_nxt = dur_of(phase_nxt, shift_nxt[0], fdur);
    end

    is_wr = (op_nxt == owbm_pkg::ACT_WBYTE || op_nxt == owbm_pkg::ACT_WBIT);
    total = (op_nxt == owbm_pkg::ACT_WBYTE || op_nxt == owbm_pkg::ACT_RBYTE) ?
            4'(owbm_pkg::BYTE_BITS) : 4'd1;

    // count down the running phase
    if (accept && phase_nxt != owbm_pkg::PH_IDLE) begin
      drive = (phase_nxt == owbm_pkg::PH_RST_LOW || phase_nxt == owbm_pkg::PH_WLOW ||
               phase_nxt == owbm_pkg::PH_RLOW);
      if (timer_nxt != '0) timer_nxt = timer_nxt - TIMER_BITS'(1);
      go = (timer_nxt == '0);
    end

    // end phases in turn, passing through empty ones, until one has ticks or the bus is idle
    for (int k = 0; k < ADV_STEPS; k++) begin
      if (go) begin
        fin = 1'b0;
        case (phase_nxt)
          owbm_pkg::PH_RST_LOW:  phase_nxt = owbm_pkg::PH_RST_WAIT;
          owbm_pkg::PH_RST_WAIT: begin
            pres_nxt  = ~line;
            phase_nxt = owbm_pkg::PH_RST_TAIL;
          end
          owbm_pkg::PH_RECOVER:  phase_nxt = is_wr ? owbm_pkg::PH_WLOW : owbm_pkg::PH_RLOW;
          owbm_pkg::PH_WLOW: begin
            if (shift_nxt[0]) phase_nxt = owbm_pkg::PH_WTAIL;
            else              fin = 1'b1;
          end
          owbm_pkg::PH_WTAIL:    fin = 1'b1;
          owbm_pkg::PH_RLOW:     phase_nxt = owbm_pkg::PH_RWAIT;
          owbm_pkg::PH_RWAIT: begin
            idx       = 3'(total - bitcnt_nxt);
            shift_nxt = shift_nxt | (8'(line) << idx);
            phase_nxt = owbm_pkg::PH_RTAIL;
          end
          owbm_pkg::PH_RTAIL:    fin = 1'b1;
          default:               phase_nxt = owbm_pkg::PH_IDLE;
        endcase

        // close a bit slot: shift out, count down, finish or recover
        if (fin) begin
          if (is_wr) shift_nxt = shift_nxt >> 1;
          bitcnt_nxt = bitcnt_nxt - 4'd1;
          if (bitcnt_nxt == 4'd0) begin
            if (!is_wr) rdata_nxt = shift_nxt;
            phase_nxt = owbm_pkg::PH_IDLE;
          end else begin
            phase_nxt = owbm_pkg::PH_RECOVER;
          end
        end

        if (phase_nxt == owbm_pkg::PH_IDLE) begin
          timer_nxt = '0;
          done      = 1'b1;
          go        = 1'b0;
        end else begin
          d = dur_of(phase_nxt, shift_nxt[0], fdur);
          if (d != '0) begin
            timer_nxt = d;
            go        = 1'b0;
          end
        end
      end
    end
  end

  // Sequencer state advances only on an accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= owbm_pkg::PH_IDLE;
      timer_r  <= '0;
      bitcnt_r <= '0;
      shift_r  <= '0;
      op_r     <= owbm_pkg::ACT_NONE;
      pres_r   <= 1'b0;
      rdata_r  <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      timer_r  <= timer_nxt;
      bitcnt_r <= bitcnt_nxt;
      shift_r  <= shift_nxt;
      op_r     <= op_nxt;
      pres_r   <= pres_nxt;
      rdata_r  <= rdata_nxt;
    end
  end

  // Result register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (accept) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_tdata_r <= {4'd0, rdata_nxt, pres_nxt, done,
                      (phase_nxt != owbm_pkg::PH_IDLE), drive};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // A running phase always has ticks left on its timer
  a_timer_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != owbm_pkg::PH_IDLE) == (timer_r != '0))
    else $error("timer and phase disagree");

  // Bit slots run only with bits left to move
  a_bits_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == owbm_pkg::PH_RECOVER || phase_r == owbm_pkg::PH_WLOW ||
     phase_r == owbm_pkg::PH_WTAIL || phase_r == owbm_pkg::PH_RLOW ||
     phase_r == owbm_pkg::PH_RWAIT || phase_r == owbm_pkg::PH_RTAIL) |-> bitcnt_r != 4'd0)
    else $error("bit slot with no bits left");

  // A completion leaves the bus idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_tdata_r[2] |-> !out_tdata_r[1])
    else $error("done reported while busy");

  // Every accepted tick yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid_r)
    else $error("accepted tick without result");

  // A held result blocks new ticks
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && !out_tready |-> !in_tready)
    else $error("tick taken over a stalled result");

endmodule
